// File: hw/rtl/piecewise_linear_warp_table_unit_assert.svh
// Assertion macros for the warp table unit.
`ifndef PIECEWISE_LINEAR_WARP_TABLE_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_WARP_TABLE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PLW_ASSERT_IMPL(label, clk_s, rst_s, lhs, rhs, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (lhs) |-> (rhs)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PLW_ASSERT_NEXT(label, clk_s, rst_s, lhs, rhs, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

// File: hw/rtl/plwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwt_pkg
// Shared types and constants of the piecewise linear warp table unit.
// ----------------------------------------------------------------------------
package plwt_pkg;
    localparam int MaxPointsDefault = 16;
    localparam int FreqW = 20;
    localparam int LenW  = 13;
    localparam int BinW  = 12;
    localparam int OutW  = 24;
    localparam int DivW  = FreqW + LenW;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BEYOND    = 2'd2,
        ST_BELOW     = 2'd3
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_DEST_LEN   = 1'b0,
        REG_UPPER_FREQ = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_INS_SCAN, S_INS_CMP, S_INS_SHIFT_RD, S_INS_SHIFT_WR, S_INS_PUT,
        S_Q_CHECK, S_Q_RD, S_Q_BOUND, S_Q_BWAIT, S_Q_NEXT, S_Q_HI_RD, S_Q_HI_BOUND,
        S_Q_HI_WAIT, S_Q_MUL0, S_Q_MUL1, S_Q_DIV1, S_Q_DIV1_WAIT, S_Q_MUL2,
        S_Q_DIV2, S_Q_DIV2_WAIT, S_DONE
    } state_t;

    // Handshake between the sequencer and the shared divider.
    typedef struct packed {
        logic            start;
        logic [63:0]     dividend;
        logic [DivW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;
endpackage

// File: hw/rtl/plwt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwt_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module plwt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem_reg [Depth];

    // Write and read at one address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end
endmodule

// File: hw/rtl/plwt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwt_div
// Restoring radix-2 divider, one quotient bit per cycle, 64 by 33 bits.
// ----------------------------------------------------------------------------
module plwt_div
    import plwt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [63:0]     quo_reg, quo_next;
    logic [DivW:0]   rem_reg, rem_next;
    logic [DivW-1:0] dvs_reg, dvs_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DivW:0]   trial;

    // Shift one bit and try to subtract
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DivW-1:0], quo_reg[63]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// File: hw/rtl/piecewise_linear_warp_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_warp_table_unit
// Sorted control point table with on-demand warped table lookup.
// ----------------------------------------------------------------------------
// Points live in one synchronous RAM holding {from, to}. One item is worked
// at a time. An insert scans for its slot and shifts the entries above it
// up. A query computes each point's bin bound with the shared 64-step
// serial divider and walks the points in order, then does two more
// divisions for the interpolation and the scaling. A query for a bin
// below the first point ends after the first bound; a bin out of range,
// or any bin while the table is empty, ends without a division.
module piecewise_linear_warp_table_unit
    import plwt_pkg::*;
#(
    parameter int MaxPoints = MaxPointsDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [FreqW-1:0]  from_freq,
    input  logic [FreqW-1:0]  to_freq,
    input  logic [BinW-1:0]   bin_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OutW-1:0]   warped_value,
    output logic [1:0]        status,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data
);
`include "piecewise_linear_warp_table_unit_assert.svh"
    localparam int AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
    localparam int CntW  = $clog2(MaxPoints + 1);
    localparam int EntW  = 2 * FreqW;
    localparam int BndW  = DivW;

    state_t state_reg, state_next;
    logic [LenW-1:0]  dest_len_reg;
    logic [FreqW-1:0] upper_reg;
    logic [CntW-1:0]  count_reg, count_next;
    logic [CntW-1:0]  idx_reg, idx_next;
    logic             op_reg;
    logic [FreqW-1:0] from_reg, to_reg;
    logic [BinW-1:0]  bin_reg;
    logic [FreqW-1:0] f0_reg, f0_next, f1_reg, f1_next, ef_reg, ef_next;
    logic [LenW-1:0]  lo_reg, lo_next;
    logic [BndW-1:0]  hi_reg, hi_next;
    logic [63:0]      acc_reg, acc_next;
    logic [OutW-1:0]  res_reg, res_next;
    logic [1:0]       st_reg, st_next;
    logic             out_valid_reg;

    logic             ram_we;
    logic [AddrW-1:0] ram_addr;
    logic [EntW-1:0]  ram_wdata, ram_rdata;
    div_req_t         dreq;
    div_rsp_t         drsp;
    logic [DivW-1:0]  eff_upper;
    logic [FreqW-1:0] rd_from, rd_to;
    logic [BndW-1:0]  bound;
    logic [52:0]      prod_a;
    logic [45:0]      prod_b;
    logic [40:0]      prod_c;

    assign rd_from   = ram_rdata[EntW-1:FreqW];
    assign rd_to     = ram_rdata[FreqW-1:0];
    assign eff_upper = DivW'((upper_reg == '0) ? FreqW'(1) : upper_reg);
    // A bound can run far past dest_len when 'to' lies above the upper bound
    assign bound     = drsp.quotient[BndW-1:0];

    plwt_ram #(.Width(EntW), .Depth(MaxPoints)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    plwt_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    assign in_ready     = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign warped_value = res_reg;
    assign status       = st_reg;

    // Sequence next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                    state_next = (op == OP_INSERT) ? S_INS_SCAN : S_Q_CHECK;
            S_INS_SCAN:
                if (count_reg == CntW'(MaxPoints) || idx_reg == count_reg)
                    state_next = (count_reg == CntW'(MaxPoints)) ? S_DONE : S_INS_PUT;
                else
                    state_next = S_INS_CMP;
            S_INS_CMP:
                if (to_reg > rd_to)
                    state_next = S_INS_SCAN;
                else
                    state_next = S_INS_SHIFT_RD;
            S_INS_SHIFT_RD:
                state_next = (idx_next == idx_reg) ? S_INS_PUT : S_INS_SHIFT_WR;
            S_INS_SHIFT_WR:
                state_next = S_INS_SHIFT_RD;
            S_INS_PUT:
                state_next = S_DONE;
            S_Q_CHECK:
                if ({3'd0, bin_reg} >= 15'(dest_len_reg) || count_reg == '0)
                    state_next = S_DONE;
                else
                    state_next = S_Q_RD;
            S_Q_RD:
                state_next = S_Q_BOUND;
            S_Q_BOUND:
                state_next = S_Q_BWAIT;
            S_Q_BWAIT:
                if (drsp.done)
                begin
                    if (idx_reg == '0 && BndW'(bin_reg) < bound)
                        state_next = S_DONE;
                    else if (idx_reg != '0 && BndW'(bin_reg) < bound)
                        state_next = S_Q_MUL0;
                    else
                        state_next = S_Q_NEXT;
                end
            S_Q_NEXT:
                state_next = (idx_reg == count_reg) ? S_Q_MUL0 : S_Q_RD;
            S_Q_MUL0:
                state_next = S_Q_MUL1;
            S_Q_MUL1:
                state_next = S_Q_DIV1;
            S_Q_DIV1:
                state_next = S_Q_DIV1_WAIT;
            S_Q_DIV1_WAIT:
                if (drsp.done)
                    state_next = S_Q_MUL2;
            S_Q_MUL2:
                state_next = S_Q_DIV2;
            S_Q_DIV2:
                state_next = S_Q_DIV2_WAIT;
            S_Q_DIV2_WAIT:
                if (drsp.done)
                    state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control per state
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        f0_next    = f0_reg;
        f1_next    = f1_reg;
        ef_next    = ef_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        ram_we     = 1'b0;
        ram_addr   = idx_reg[AddrW-1:0];
        ram_wdata  = {from_reg, to_reg};
        dreq       = '0;
        prod_a     = '0;
        prod_b     = '0;
        prod_c     = '0;
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                // Hold the waiting result until a new item is taken
                if (in_valid && in_ready)
                begin
                    res_next = '0;
                    st_next  = ST_OK;
                end
            end
            S_INS_SCAN:
            begin
                if (count_reg == CntW'(MaxPoints))
                    st_next = ST_FULL;
            end
            S_INS_CMP:
            begin
                if (to_reg > rd_to)
                    idx_next = idx_reg + CntW'(1);
                else
                    idx_next = count_reg;
            end
            S_INS_SHIFT_RD:
            begin
                // idx walks down from count to the slot; read the entry below
                ram_addr = AddrW'(idx_reg - CntW'(1));
                if (idx_reg == ef_reg[CntW-1:0])
                    idx_next = idx_reg;
                else
                    idx_next = idx_reg - CntW'(1);
            end
            S_INS_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = AddrW'(idx_reg + CntW'(1));
                ram_wdata = ram_rdata;
            end
            S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_addr   = ef_reg[AddrW-1:0];
                count_next = count_reg + CntW'(1);
            end
            S_Q_CHECK:
            begin
                if ({3'd0, bin_reg} >= 15'(dest_len_reg))
                    st_next = ST_BEYOND;
                else if (count_reg == '0)
                    st_next = ST_BELOW;
            end
            S_Q_BOUND:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = 64'(rd_to) * 64'(dest_len_reg);
                dreq.divisor  = eff_upper;
                ef_next       = rd_from;
            end
            S_Q_BWAIT:
            begin
                if (drsp.done)
                begin
                    if (BndW'(bin_reg) < bound)
                    begin
                        if (idx_reg == '0)
                            st_next = ST_BELOW;
                        hi_next = bound;
                        f1_next = ef_reg;
                    end
                    else
                    begin
                        lo_next  = LenW'(bound);
                        f0_next  = ef_reg;
                        idx_next = idx_reg + CntW'(1);
                    end
                end
            end
            S_Q_NEXT:
            begin
                if (idx_reg == count_reg)
                begin
                    hi_next = BndW'(dest_len_reg);
                    f1_next = upper_reg;
                end
            end
            S_Q_MUL0:
            begin
                prod_a   = 53'(f0_reg) * 53'(hi_reg - BndW'(bin_reg));
                acc_next = 64'(prod_a);
            end
            S_Q_MUL1:
            begin
                prod_b   = 46'(f1_reg) * 46'(13'(bin_reg) - lo_reg);
                acc_next = (acc_reg + 64'(prod_b)) << 8;
            end
            S_Q_DIV1:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = acc_reg;
                dreq.divisor  = DivW'(hi_reg - BndW'(lo_reg));
            end
            S_Q_DIV1_WAIT:
                if (drsp.done)
                    acc_next = drsp.quotient;
            S_Q_MUL2:
            begin
                // The interpolated value stays below 2^28
                prod_c   = 41'(acc_reg[27:0]) * 41'(dest_len_reg);
                acc_next = 64'(prod_c);
            end
            S_Q_DIV2:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = acc_reg;
                dreq.divisor  = eff_upper;
            end
            S_Q_DIV2_WAIT:
                if (drsp.done)
                    res_next = (drsp.quotient > 64'(24'hFFFFFF)) ? 24'hFFFFFF
                                                                 : drsp.quotient[OutW-1:0];
            default:
            begin
            end
        endcase
        // Slot found: remember it and start shifting from the top
        if (state_reg == S_INS_CMP && !(to_reg > rd_to))
            ef_next = {{(FreqW-CntW){1'b0}}, idx_reg};
        if (state_reg == S_INS_SCAN && idx_reg == count_reg)
            ef_next = {{(FreqW-CntW){1'b0}}, idx_reg};
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            dest_len_reg  <= LenW'(1024);
            upper_reg     <= FreqW'(352800);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_DONE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DEST_LEN)
                    dest_len_reg <= cfg_data[LenW-1:0];
                else
                    upper_reg <= cfg_data[FreqW-1:0];
            end
        end
    end

    // Capture the item and working values
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= op;
            from_reg <= from_freq;
            to_reg   <= to_freq;
            bin_reg  <= bin_index;
        end
        idx_reg <= idx_next;
        f0_reg  <= f0_next;
        f1_reg  <= f1_next;
        ef_reg  <= ef_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        st_reg  <= st_next;
    end

    `PLW_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= CntW'(MaxPoints),
        "point count beyond table depth")
    `PLW_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && status != ST_OK,
        warped_value == '0, "nonzero value with error status")
    `PLW_ASSERT_NEXT(a_put_grows, clk, rst_n, state_reg == S_INS_PUT,
        count_reg == $past(count_reg) + CntW'(1), "insert did not grow the table")
    `PLW_ASSERT_IMPL(a_insert_status, clk, rst_n, state_reg == S_DONE && op_reg == OP_INSERT,
        st_reg == ST_OK || st_reg == ST_FULL, "insert with query status")
endmodule

// File: sim/tb_piecewise_linear_warp_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_warp_table_unit
// Self-checking bench for the warp table unit: control point inserts and
// warped bin queries under several table sizes and upper frequency bounds.
// ----------------------------------------------------------------------------
// A directed table covers the edge cases first. Random phases then fill the
// point table and query it, with reconfiguration between phases. Each
// transfer on the input channel is run through a local predictor. Each
// result transfer is compared with the oldest expected result.
module tb_piecewise_linear_warp_table_unit;
    import plwt_pkg::*;

    localparam int NumPts   = 16;
    localparam int CycLimit = 10000000;

    typedef struct packed {
        logic [OutW-1:0] value;
        status_t         stat;
    } warp_res_t;

    typedef struct {
        op_t              op;
        logic [FreqW-1:0] from_f;
        logic [FreqW-1:0] to_f;
        logic [BinW-1:0]  bin;
        logic             chk;
        warp_res_t        res;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              op = 1'b0;
    logic [FreqW-1:0]  from_freq = '0;
    logic [FreqW-1:0]  to_freq = '0;
    logic [BinW-1:0]   bin_index = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [OutW-1:0]   warped_value;
    logic [1:0]        status;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = 1'b0;
    logic [31:0]       cfg_data = '0;

    // predictor state
    logic [12:0]       pr_dest_len;
    logic [FreqW-1:0]  pr_upper;
    logic [FreqW-1:0]  pr_from [NumPts];
    logic [FreqW-1:0]  pr_to [NumPts];
    int                pr_count;

    warp_res_t         expected_q[$];
    int                errors = 0;
    int                results_seen = 0;
    int                queries_ok = 0;
    int                cycles = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;

    piecewise_linear_warp_table_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .from_freq(from_freq), .to_freq(to_freq), .bin_index(bin_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .warped_value(warped_value), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // abort on runaway
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycLimit)
        begin
            $display("timeout at %0t", $time);
            $display("tb_piecewise_linear_warp_table_unit: errors");
            $finish;
        end
    end

    function automatic logic [63:0] bound_of(input logic [FreqW-1:0] to_f);
        logic [63:0] up;
        up = (pr_upper == 0) ? 64'd1 : 64'(pr_upper);
        return (64'(to_f) * 64'(pr_dest_len)) / up;
    endfunction

    function automatic warp_res_t warp_lookup(input logic [BinW-1:0] bin);
        warp_res_t   r;
        int          seg;
        logic [63:0] lo, hi, f0, f1, span, num, fint, up, scaled;
        r.value = '0;
        if (64'(bin) >= 64'(pr_dest_len))
        begin
            r.stat = ST_BEYOND;
            return r;
        end
        if (pr_count == 0 || 64'(bin) < bound_of(pr_to[0]))
        begin
            r.stat = ST_BELOW;
            return r;
        end
        seg = 0;
        for (int m = 1; m < pr_count; m++)
            if (bound_of(pr_to[m]) <= 64'(bin))
                seg = m;
        lo = bound_of(pr_to[seg]);
        f0 = 64'(pr_from[seg]);
        if (seg + 1 < pr_count)
        begin
            hi = bound_of(pr_to[seg + 1]);
            f1 = 64'(pr_from[seg + 1]);
        end
        else
        begin
            hi = 64'(pr_dest_len);
            f1 = 64'(pr_upper);
        end
        span = hi - lo;
        if (span == 0)
        begin
            r.stat = ST_BELOW;
            return r;
        end
        up = (pr_upper == 0) ? 64'd1 : 64'(pr_upper);
        num = f0 * (hi - 64'(bin)) + f1 * (64'(bin) - lo);
        fint = (num * 256) / span;
        scaled = (fint * 64'(pr_dest_len)) / up;
        r.value = (scaled > 64'hFFFFFF) ? 24'hFFFFFF : scaled[23:0];
        r.stat = ST_OK;
        return r;
    endfunction

    function automatic warp_res_t warp_insert(input logic [FreqW-1:0] from_f,
                                              input logic [FreqW-1:0] to_f);
        warp_res_t r;
        int        pos;
        r.value = '0;
        if (pr_count >= NumPts)
        begin
            r.stat = ST_FULL;
            return r;
        end
        pos = 0;
        while (pos < pr_count && to_f > pr_to[pos])
            pos++;
        for (int m = pr_count; m > pos; m--)
        begin
            pr_from[m] = pr_from[m - 1];
            pr_to[m] = pr_to[m - 1];
        end
        pr_from[pos] = from_f;
        pr_to[pos] = to_f;
        pr_count++;
        r.stat = ST_OK;
        return r;
    endfunction

    // check every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        warp_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d status=%0d",
                         $time, warped_value, status);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (status != e.stat)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.stat, status);
                    errors++;
                end
                if (warped_value != e.value)
                begin
                    $display("%0t: warped_value expected %0d actual %0d",
                             $time, e.value, warped_value);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one register write; the channel then goes quiet before the next write
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_DEST_LEN)
            pr_dest_len = data[12:0];
        else
            pr_upper = data[FreqW-1:0];
    endtask

    // Send one item; predicted result is pushed at the transfer edge.
    // Valid stays high into the next item; drain drops it.
    task automatic send_item(input op_t o, input logic [FreqW-1:0] f,
                             input logic [FreqW-1:0] t, input logic [BinW-1:0] b,
                             input logic chk, input warp_res_t typed);
        warp_res_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        from_freq <= f;
        to_freq <= t;
        bin_index <= b;
        do @(posedge clk); while (!in_ready);
        if (o == OP_INSERT)
            r = warp_insert(f, t);
        else
            r = warp_lookup(b);
        if (o == OP_QUERY && r.stat == ST_OK)
            queries_ok++;
        if (chk && r != typed)
        begin
            $display("%0t: table row expected value=%0d status=%0d, predictor %0d/%0d",
                     $time, typed.value, typed.stat, r.value, r.stat);
            errors++;
        end
        expected_q.push_back(r);
    endtask

    // wait for all results, then let the block settle before reconfiguring
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [FreqW-1:0] rand_to();
        if ($urandom_range(3) == 0)
            return FreqW'($urandom);
        return FreqW'($urandom_range(pr_upper));
    endfunction

    function automatic logic [BinW-1:0] rand_bin();
        if ($urandom_range(7) == 0 || pr_dest_len == 0)
            return BinW'($urandom);
        return BinW'($urandom_range(pr_dest_len - 1));
    endfunction

    // Clear the table by reset is not allowed; instead reuse a full or
    // partial table: the point store only grows. Phases therefore fill it.
    task automatic random_phase(input int n_items);
        int ins_left;
        ins_left = NumPts - pr_count;
        for (int i = 0; i < n_items; i++)
        begin
            if (ins_left > 0 && $urandom_range(3) == 0)
            begin
                send_item(OP_INSERT, FreqW'($urandom), rand_to(), '0, 1'b0, '0);
                ins_left--;
            end
            else if ($urandom_range(19) == 0)
                send_item(OP_INSERT, FreqW'($urandom), FreqW'($urandom), '0, 1'b0, '0);
            else
                send_item(OP_QUERY, FreqW'($urandom), FreqW'($urandom), rand_bin(),
                          1'b0, '0);
        end
    endtask

    localparam warp_res_t RES_OK    = '{value: '0, stat: ST_OK};
    localparam warp_res_t RES_FULL  = '{value: '0, stat: ST_FULL};
    localparam warp_res_t RES_BEYOND = '{value: '0, stat: ST_BEYOND};
    localparam warp_res_t RES_BELOW = '{value: '0, stat: ST_BELOW};

    stim_row_t directed_rows[] = '{
        '{OP_QUERY,  20'd0,       20'd0,       12'd0,    1'b1, RES_BELOW},
        '{OP_QUERY,  20'hFFFFF,   20'hFFFFF,   12'd4095, 1'b1, RES_BEYOND},
        '{OP_QUERY,  20'd0,       20'd0,       12'd1024, 1'b1, RES_BEYOND},
        '{OP_QUERY,  20'd0,       20'd0,       12'd1023, 1'b1, RES_BELOW},
        '{OP_INSERT, 20'd88200,   20'd176400,  12'd0,    1'b1, RES_OK},
        '{OP_QUERY,  20'd0,       20'd0,       12'd511,  1'b1, RES_BELOW},
        '{OP_QUERY,  20'd0,       20'd0,       12'd512,  1'b0, RES_OK},
        '{OP_QUERY,  20'd0,       20'd0,       12'd1023, 1'b0, RES_OK},
        '{OP_INSERT, 20'd0,       20'd0,       12'd0,    1'b1, RES_OK},
        '{OP_QUERY,  20'd0,       20'd0,       12'd0,    1'b0, RES_OK},
        '{OP_QUERY,  20'd0,       20'd0,       12'd300,  1'b0, RES_OK},
        '{OP_INSERT, 20'hFFFFF,   20'd176400,  12'd0,    1'b1, RES_OK},
        '{OP_INSERT, 20'd5,       20'd176401,  12'd0,    1'b1, RES_OK},
        '{OP_QUERY,  20'd0,       20'd0,       12'd512,  1'b0, RES_OK},
        '{OP_QUERY,  20'd0,       20'd0,       12'd513,  1'b0, RES_OK},
        '{OP_INSERT, 20'hFFFFF,   20'hFFFFF,   12'd0,    1'b1, RES_OK},
        '{OP_QUERY,  20'd0,       20'd0,       12'd1023, 1'b0, RES_OK},
        '{OP_QUERY,  20'hAAAAA,   20'h55555,   12'h555,  1'b0, RES_OK},
        '{OP_QUERY,  20'h55555,   20'hAAAAA,   12'hAAA,  1'b0, RES_OK}
    };

    initial
    begin
        pr_dest_len = 13'd1024;
        pr_upper = 20'd352800;
        pr_count = 0;
        for (int m = 0; m < NumPts; m++)
        begin
            pr_from[m] = '0;
            pr_to[m] = '0;
        end
        send_idle_pct = 9;
        recv_idle_pct = 53;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table at reset configuration
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].from_f, directed_rows[i].to_f,
                      directed_rows[i].bin, directed_rows[i].chk, directed_rows[i].res);
        // fill to capacity, then one insert more must be refused
        while (pr_count < NumPts)
            send_item(OP_INSERT, FreqW'($urandom), FreqW'($urandom_range(352800)), '0,
                      1'b1, RES_OK);
        send_item(OP_INSERT, 20'd1, 20'd1, '0, 1'b1, RES_FULL);
        drain();

        // extreme settings on the full table
        write_reg(REG_DEST_LEN, 32'd4096);
        write_reg(REG_UPPER_FREQ, 32'hFFFFF);
        random_phase(120);
        drain();
        write_reg(REG_DEST_LEN, 32'h1);
        write_reg(REG_UPPER_FREQ, 32'd16);
        send_item(OP_QUERY, '0, '0, 12'd1, 1'b1, RES_BEYOND);
        random_phase(40);
        drain();
        write_reg(REG_DEST_LEN, 32'h0);
        send_item(OP_QUERY, '0, '0, 12'd0, 1'b1, RES_BEYOND);
        drain();
        write_reg(REG_UPPER_FREQ, 32'h0);
        write_reg(REG_DEST_LEN, 32'h1FFF);
        random_phase(40);
        drain();

        send_idle_pct = 53;
        recv_idle_pct = 9;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_DEST_LEN, 32'($urandom_range(4096, 1)));
            write_reg(REG_UPPER_FREQ, 32'($urandom_range(20'hFFFFF, 16)));
            random_phase(110);
            drain();
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_DEST_LEN, 32'($urandom_range(512, 8)));
            write_reg(REG_UPPER_FREQ, 32'($urandom_range(20'hFFFFF, 16)));
            random_phase(110);
            drain();
        end
        write_reg(REG_DEST_LEN, 32'd1024);
        write_reg(REG_UPPER_FREQ, 32'd352800);
        random_phase(30);
        drain();

        $display("covered %0d results, %0d successful lookups, %0d stored points,",
                 results_seen, queries_ok, pr_count);
        $display("table lengths 0 to 8191 and upper bounds 0 to full scale");
        if (errors == 0)
            $display("tb_piecewise_linear_warp_table_unit: clean");
        else
            $display("tb_piecewise_linear_warp_table_unit: errors");
        $finish;
    end
endmodule
